### rtl/core/pfbd_pkg.sv
package pfbd_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_packet;
    } t_in_item;

    typedef struct packed {
        logic        uart_valid;
        logic [7:0]  uart_byte;
        logic        slot_released;
        logic        packet_dropped;
        logic        packet_truncated;
        logic        fifo_full;
        logic        fifo_empty;
        logic        fifo_half_full;
        logic [3:0]  slots_used;
        logic [31:0] rx_byte_total;
        logic [31:0] tx_byte_total;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_BYTE_LAST,
        OP_EMPTY,
        OP_DRAIN
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_head;

    localparam int QUEUE_DEPTH = 2;

endpackage

### rtl/core/pfbd_front.sv
module pfbd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pfbd_pkg::t_in_item i_in_data,
    output pfbd_pkg::t_q_head o_head,
    input  logic              i_pop
);

    pfbd_pkg::t_op r_q [pfbd_pkg::QUEUE_DEPTH];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    pfbd_pkg::t_op op_in;
    logic          push;
    logic          pop;

    always_comb begin
        op_in.data = i_in_data.data_byte;
        priority if (i_in_data.command) begin
            op_in.kind = pfbd_pkg::OP_DRAIN;
        end else if (i_in_data.empty_packet) begin
            op_in.kind = pfbd_pkg::OP_EMPTY;
        end else if (i_in_data.last_byte) begin
            op_in.kind = pfbd_pkg::OP_BYTE_LAST;
        end else begin
            op_in.kind = pfbd_pkg::OP_BYTE;
        end
    end

    assign o_in_ready   = (r_cnt != 2'(pfbd_pkg::QUEUE_DEPTH));
    assign push         = i_in_valid && o_in_ready;
    assign pop          = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.op    = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= op_in;
        end
    end

endmodule

### rtl/core/pfbd_back.sv
module pfbd_back #(
    parameter int SLOT_COUNT = 8,
    parameter int SLOT_BYTES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfbd_pkg::t_q_head   i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pfbd_pkg::t_out_item o_out_data
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int PW = $clog2(2 * SLOT_COUNT);
    localparam int BW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int CW = $clog2(SLOT_BYTES + 1);
    localparam int AW = $clog2(SLOT_COUNT * SLOT_BYTES);
    localparam int UW = $clog2(SLOT_COUNT + 1);
    localparam int MEM_DEPTH = SLOT_COUNT * SLOT_BYTES;
    localparam logic [PW-1:0] PTR_LAST = PW'(2 * SLOT_COUNT - 1);
    localparam logic [CW-1:0] SB_C     = CW'(SLOT_BYTES);
    localparam logic [UW-1:0] FULL_C   = UW'(SLOT_COUNT);
    localparam logic [UW-1:0] HALF_C   = UW'(SLOT_COUNT / 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_EMIT
    } t_state;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p >= PW'(SLOT_COUNT)) ? p - PW'(SLOT_COUNT) : p;
        return q[SW-1:0];
    endfunction

    function automatic logic [UW-1:0] used_of(input logic [PW-1:0] wp,
                                              input logic [PW-1:0] rp);
        logic [PW:0] d;
        d = {1'b0, wp} - {1'b0, rp};
        if (d[PW]) begin
            d = d + (PW+1)'(2 * SLOT_COUNT);
        end
        return d[UW-1:0];
    endfunction

    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s,
                                                input logic [CW-1:0] idx);
        logic [31:0] a;
        a = 32'(s) * 32'(SLOT_BYTES) + 32'(idx);
        return a[AW-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [PW-1:0]       r_wp, n_wp;
    logic [PW-1:0]       r_rp, n_rp;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic                r_disc, n_disc;
    logic [CW-1:0]       r_send_len, n_send_len;
    logic [CW-1:0]       r_pos, n_pos;
    logic                r_sending, n_sending;
    logic [31:0]         r_rx, n_rx;
    logic [31:0]         r_tx, n_tx;
    logic [CW-1:0]       r_cp_rd, n_cp_rd;
    logic                r_cp_pend, n_cp_pend;
    logic [BW-1:0]       r_cp_wr, n_cp_wr;
    logic [SW-1:0]       r_cp_base, n_cp_base;
    logic                r_out_valid, n_out_valid;
    pfbd_pkg::t_out_item r_out, n_out;

    logic [CW-1:0]       r_len [SLOT_COUNT];
    logic [7:0]          r_slot_mem [MEM_DEPTH];
    logic [7:0]          r_send_mem [SLOT_BYTES];
    logic [7:0]          r_slot_rd;
    logic [7:0]          r_send_rd;

    logic                slot_we, slot_re, send_re, len_we;
    logic [AW-1:0]       slot_waddr, slot_raddr;
    logic [7:0]          slot_wdata;
    logic [BW-1:0]       send_raddr;
    logic [SW-1:0]       len_idx;
    logic [CW-1:0]       len_val;
    logic                pop;
    logic                ld;
    logic                f_valid, f_rel, f_drop, f_trunc;
    logic [7:0]          f_byte;
    logic [UW-1:0]       used_cur, used_new;
    logic [31:0]         used_ext;
    logic [CW-1:0]       cnt_cur, cnt_new, ld_len, pos_inc;
    logic                disc_cur, ends;

    assign pop      = (r_state == S_IDLE) && i_head.valid && (!r_out_valid || i_out_ready);
    assign o_pop    = pop;
    assign used_cur = used_of(r_wp, r_rp);
    assign pos_inc  = r_pos + CW'(1);
    assign ld_len   = r_len[slot_of(r_rp)];

    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_cnt      = r_cnt;
        n_busy     = r_busy;
        n_disc     = r_disc;
        n_send_len = r_send_len;
        n_pos      = r_pos;
        n_sending  = r_sending;
        n_rx       = r_rx;
        n_tx       = r_tx;
        n_cp_rd    = r_cp_rd;
        n_cp_pend  = 1'b0;
        n_cp_wr    = r_cp_wr;
        n_cp_base  = r_cp_base;
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = i_head.op.data;
        slot_re    = 1'b0;
        slot_raddr = '0;
        send_re    = 1'b0;
        send_raddr = r_pos[BW-1:0];
        len_we     = 1'b0;
        len_idx    = slot_of(r_wp);
        len_val    = '0;
        ld         = 1'b0;
        f_valid    = 1'b0;
        f_byte     = 8'd0;
        f_rel      = 1'b0;
        f_drop     = 1'b0;
        f_trunc    = 1'b0;
        cnt_cur    = r_busy ? r_cnt : '0;
        disc_cur   = r_busy ? r_disc : (used_cur >= FULL_C);
        cnt_new    = cnt_cur;
        ends       = (i_head.op.kind != pfbd_pkg::OP_BYTE);

        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    ld = 1'b1;
                    unique case (i_head.op.kind)
                        pfbd_pkg::OP_BYTE, pfbd_pkg::OP_BYTE_LAST, pfbd_pkg::OP_EMPTY: begin
                            f_drop = !r_busy && disc_cur;
                            if (disc_cur) begin
                                n_busy = !ends;
                                n_disc = !ends;
                                n_cnt  = '0;
                            end else begin
                                n_disc = 1'b0;
                                if (i_head.op.kind != pfbd_pkg::OP_EMPTY) begin
                                    if (cnt_cur < SB_C) begin
                                        slot_we    = 1'b1;
                                        slot_waddr = slot_addr(slot_of(r_wp), cnt_cur);
                                        cnt_new    = cnt_cur + CW'(1);
                                        n_rx       = r_rx + 32'd1;
                                    end else begin
                                        f_trunc = 1'b1;
                                    end
                                end
                                if (ends) begin
                                    len_we  = 1'b1;
                                    len_val = cnt_new;
                                    n_wp    = ptr_next(r_wp);
                                    n_cnt   = '0;
                                    n_busy  = 1'b0;
                                end else begin
                                    n_cnt  = cnt_new;
                                    n_busy = 1'b1;
                                end
                            end
                        end
                        pfbd_pkg::OP_DRAIN: begin
                            if (r_sending) begin
                                ld         = 1'b0;
                                send_re    = 1'b1;
                                n_pos      = pos_inc;
                                n_tx       = r_tx + 32'd1;
                                n_sending  = (pos_inc < r_send_len);
                                n_state    = S_EMIT;
                            end else if (r_wp != r_rp) begin
                                f_rel      = 1'b1;
                                n_send_len = ld_len;
                                n_pos      = '0;
                                n_sending  = (ld_len != '0);
                                n_rp       = ptr_next(r_rp);
                                n_cp_base  = slot_of(r_rp);
                                n_cp_rd    = '0;
                                if (ld_len != '0) begin
                                    n_state = S_COPY;
                                end
                            end
                        end
                    endcase
                end
            end
            S_COPY: begin
                if (r_cp_rd < r_send_len) begin
                    slot_re    = 1'b1;
                    slot_raddr = slot_addr(r_cp_base, r_cp_rd);
                    n_cp_rd    = r_cp_rd + CW'(1);
                    n_cp_pend  = 1'b1;
                    n_cp_wr    = r_cp_rd[BW-1:0];
                end else if (!r_cp_pend) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                ld      = 1'b1;
                f_valid = 1'b1;
                f_byte  = r_send_rd;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        used_new = used_of(n_wp, n_rp);
        used_ext = 32'(used_new);

        n_out_valid = ld || (r_out_valid && !i_out_ready);
        n_out       = r_out;
        if (ld) begin
            n_out.uart_valid       = f_valid;
            n_out.uart_byte        = f_byte;
            n_out.slot_released    = f_rel;
            n_out.packet_dropped   = f_drop;
            n_out.packet_truncated = f_trunc;
            n_out.fifo_full        = (used_new >= FULL_C);
            n_out.fifo_empty       = (n_wp == n_rp);
            n_out.fifo_half_full   = (used_new >= HALF_C);
            n_out.slots_used       = used_ext[3:0];
            n_out.rx_byte_total    = n_rx;
            n_out.tx_byte_total    = n_tx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_cnt       <= '0;
            r_busy      <= 1'b0;
            r_disc      <= 1'b0;
            r_send_len  <= '0;
            r_pos       <= '0;
            r_sending   <= 1'b0;
            r_rx        <= '0;
            r_tx        <= '0;
            r_cp_rd     <= '0;
            r_cp_pend   <= 1'b0;
            r_cp_wr     <= '0;
            r_cp_base   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_cnt       <= n_cnt;
            r_busy      <= n_busy;
            r_disc      <= n_disc;
            r_send_len  <= n_send_len;
            r_pos       <= n_pos;
            r_sending   <= n_sending;
            r_rx        <= n_rx;
            r_tx        <= n_tx;
            r_cp_rd     <= n_cp_rd;
            r_cp_pend   <= n_cp_pend;
            r_cp_wr     <= n_cp_wr;
            r_cp_base   <= n_cp_base;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len[len_idx] <= len_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re) begin
            r_slot_rd <= r_slot_mem[slot_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cp_pend) begin
            r_send_mem[r_cp_wr] <= r_slot_rd;
        end
        if (send_re) begin
            r_send_rd <= r_send_mem[send_raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_copy_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> !pop)
        else $error("item taken during slot copy");

    a_send_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sending |-> (r_pos < r_send_len))
        else $error("send position beyond send length");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        used_cur <= FULL_C)
        else $error("used slots exceed slot count");

    a_disc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disc |-> r_busy)
        else $error("discarding outside a packet");

    a_emit_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_head.op.kind == pfbd_pkg::OP_DRAIN && r_sending)
        |=> (r_state == S_EMIT) && !r_out_valid)
        else $error("emit without free output register");

endmodule

### rtl/core/packet_fifo_byte_drain_top.sv
// Packet FIFO with byte drain.
// Input channel (i_in_valid / o_in_ready / i_in_data): one transfer is either a
// received packet byte (command 0, with last_byte or empty_packet ending the
// packet) or a drain tick (command 1). Every input transfer yields exactly one
// output transfer (o_out_valid / i_out_ready / o_out_data) with flags, FIFO
// status and running byte totals, in order.
// A two-entry input queue decouples the input side from the executing back end.
// Results pass through the input queue and the output register, and a byte
// emitting tick also through the registered send buffer read.
// Throughput: one item per cycle for writes and idle ticks while the output
// register can take a result; an emitting tick holds off the next item. A tick
// that loads a slot of N > 0 bytes copies it into the send buffer one byte per
// cycle through the single slot store read port, and no item starts meanwhile.
// Reset clears pointers, counters and flags; the slot and send stores are not
// cleared. When the receiver stalls the result is held in the output register,
// the input queue fills and o_in_ready drops; nothing is lost.
module packet_fifo_byte_drain_top #(
    parameter int SLOT_COUNT = 8,
    parameter int SLOT_BYTES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pfbd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pfbd_pkg::t_out_item o_out_data
);

    pfbd_pkg::t_q_head head;
    logic              pop;

    pfbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_head     (head),
        .i_pop      (pop)
    );

    pfbd_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### tb/packet_fifo_byte_drain_top_tb.sv
module packet_fifo_byte_drain_top_tb;

    localparam int SLOT_COUNT     = 8;
    localparam int SLOT_BYTES     = 256;
    localparam int QUIET_LIMIT    = 3000;
    localparam int RX_HOLD_CYCLES = 150;

    class packet_drain_scoreboard;
        localparam int SLOTS = 8;
        localparam int BYTES = 256;

        bit [7:0]  slot_mem [SLOTS*BYTES];
        bit [8:0]  slot_len [SLOTS];
        bit [3:0]  wr_ptr, rd_ptr;
        bit [8:0]  wr_count;
        bit        wr_busy, wr_discard;
        bit [7:0]  send_buf [BYTES];
        bit [8:0]  send_len, send_pos;
        bit        send_active;
        bit [31:0] rx_total, tx_total;
        pfbd_pkg::t_out_item pending_results[$];
        int        n_items, n_results, n_errors;
        int        n_released, n_empty_loads, n_emitted, n_dropped, n_truncated;

        function void note_transfer_in(input pfbd_pkg::t_in_item it);
            pfbd_pkg::t_out_item r;
            bit [3:0]  used;
            bit        ends;
            int        base;
            r = '0;
            n_items++;
            if (it.command == 1'b0) begin
                ends = it.empty_packet || it.last_byte;
                if (!wr_busy) begin
                    used = wr_ptr - rd_ptr;
                    wr_busy = 1'b1;
                    wr_count = '0;
                    wr_discard = (used >= SLOTS);
                    r.packet_dropped = wr_discard;
                end
                if (wr_discard) begin
                    if (ends) begin
                        wr_discard = 1'b0;
                        wr_busy = 1'b0;
                        wr_count = '0;
                    end
                end else begin
                    if (!it.empty_packet) begin
                        if (wr_count < BYTES) begin
                            slot_mem[int'(wr_ptr[2:0]) * BYTES + int'(wr_count)] = it.data_byte;
                            wr_count++;
                            rx_total++;
                        end else begin
                            r.packet_truncated = 1'b1;
                        end
                    end
                    if (ends) begin
                        slot_len[wr_ptr[2:0]] = wr_count;
                        wr_ptr++;
                        wr_count = '0;
                        wr_busy = 1'b0;
                    end
                end
            end else if (!send_active) begin
                if (wr_ptr != rd_ptr) begin
                    base = int'(rd_ptr[2:0]) * BYTES;
                    send_len = slot_len[rd_ptr[2:0]];
                    for (int k = 0; k < int'(send_len); k++) send_buf[k] = slot_mem[base + k];
                    send_pos = '0;
                    send_active = (send_len != 0);
                    rd_ptr++;
                    r.slot_released = 1'b1;
                    if (send_len == 0) n_empty_loads++;
                end
            end else begin
                r.uart_valid = 1'b1;
                r.uart_byte = send_buf[send_pos];
                send_pos++;
                tx_total++;
                if (send_pos >= send_len) send_active = 1'b0;
            end
            used = wr_ptr - rd_ptr;
            r.fifo_full = (used >= SLOTS);
            r.fifo_empty = (wr_ptr == rd_ptr);
            r.fifo_half_full = (used >= SLOTS / 2);
            r.slots_used = used;
            r.rx_byte_total = rx_total;
            r.tx_byte_total = tx_total;
            n_released += r.slot_released;
            n_emitted += r.uart_valid;
            n_dropped += r.packet_dropped;
            n_truncated += r.packet_truncated;
            pending_results.push_back(r);
        endfunction

        task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
            n_errors++;
            $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                     n_results, what, got, want);
        endtask

        task cmp_field(input string what, input logic [31:0] got, input logic [31:0] want);
            if (got !== want) report_mismatch(what, got, want);
        endtask

        task check_transfer_out(input pfbd_pkg::t_out_item got);
            pfbd_pkg::t_out_item want;
            n_results++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", got.tx_byte_total, 0);
                return;
            end
            want = pending_results.pop_front();
            cmp_field("uart_valid", got.uart_valid, want.uart_valid);
            cmp_field("uart_byte", got.uart_byte, want.uart_byte);
            cmp_field("slot_released", got.slot_released, want.slot_released);
            cmp_field("packet_dropped", got.packet_dropped, want.packet_dropped);
            cmp_field("packet_truncated", got.packet_truncated, want.packet_truncated);
            cmp_field("fifo_full", got.fifo_full, want.fifo_full);
            cmp_field("fifo_empty", got.fifo_empty, want.fifo_empty);
            cmp_field("fifo_half_full", got.fifo_half_full, want.fifo_half_full);
            cmp_field("slots_used", got.slots_used, want.slots_used);
            cmp_field("rx_byte_total", got.rx_byte_total, want.rx_byte_total);
            cmp_field("tx_byte_total", got.tx_byte_total, want.tx_byte_total);
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    pfbd_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    pfbd_pkg::t_out_item o_out_data;

    packet_drain_scoreboard sb;
    bit tx_idling   = 1'b1;
    bit rx_idling   = 1'b1;
    bit rx_hold_req = 1'b0;
    int quiet_cycles;
    bit pkt_open;
    bit pkt_ends_empty;
    int pkt_left;

    packet_fifo_byte_drain_top #(
        .SLOT_COUNT(SLOT_COUNT),
        .SLOT_BYTES(SLOT_BYTES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_transfer_out(o_out_data);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("FAIL packet_fifo_byte_drain_top");
                $finish;
            end
        end
    end

    // receiver: random back-pressure bursts, plus one long hold-off on request
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idling && $urandom_range(0, 13) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic drive_item(input pfbd_pkg::t_in_item it);
        if (tx_idling && $urandom_range(0, 11) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_transfer_in(it);
    endtask

    task automatic put_write(input logic [7:0] data, input logic last, input logic empty);
        pfbd_pkg::t_in_item it;
        it.command = 1'b0;
        it.data_byte = data;
        it.last_byte = last;
        it.empty_packet = empty;
        drive_item(it);
    endtask

    task automatic put_drain();
        pfbd_pkg::t_in_item it;
        it.command = 1'b1;
        it.data_byte = 8'($urandom_range(0, 255));
        it.last_byte = 1'($urandom_range(0, 1));
        it.empty_packet = 1'($urandom_range(0, 1));
        drive_item(it);
    endtask

    // mostly well-formed packets with random content, some stray writes, and drain ticks at drain_pct
    function automatic pfbd_pkg::t_in_item next_random_item(input int drain_pct);
        pfbd_pkg::t_in_item it;
        it.command = 1'b0;
        it.data_byte = 8'($urandom_range(0, 255));
        it.last_byte = 1'($urandom_range(0, 1));
        it.empty_packet = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < drain_pct) begin
            it.command = 1'b1;
        end else if ($urandom_range(0, 39) == 0) begin
            if (it.last_byte || it.empty_packet) pkt_open = 1'b0;
        end else begin
            if (!pkt_open) begin
                pkt_open = 1'b1;
                pkt_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                       : $urandom_range(0, 6);
                pkt_ends_empty = ($urandom_range(0, 5) == 0) || (pkt_left == 0);
            end
            it.empty_packet = 1'b0;
            if (pkt_left == 0) begin
                it.empty_packet = 1'b1;
                pkt_open = 1'b0;
            end else begin
                pkt_left--;
                it.last_byte = (pkt_left == 0) && !pkt_ends_empty;
                if (it.last_byte) pkt_open = 1'b0;
            end
        end
        return it;
    endfunction

    task automatic run_random(input int count, input int drain_pct);
        repeat (count) drive_item(next_random_item(drain_pct));
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic drain_all();
        while (sb.wr_ptr != sb.rd_ptr || sb.send_active) put_drain();
    endtask

    // full-size slot with overflow bytes, then drained to the last byte
    task automatic run_overlong_packet();
        if (sb.wr_busy) put_write(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        pkt_open = 1'b0;
        drain_all();
        for (int n = 0; n < SLOT_BYTES + 2; n++)
            put_write(8'($urandom_range(0, 255)), n == SLOT_BYTES + 1, 1'b0);
        drain_all();
    endtask

    initial begin
        sb = new;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_drain();
        repeat (SLOT_COUNT) put_write(8'h00, 1'b0, 1'b1);
        put_write(8'hFF, 1'b0, 1'b0);
        put_write(8'h00, 1'b1, 1'b0);
        repeat (SLOT_COUNT) put_drain();
        put_write(8'hFF, 1'b0, 1'b0);
        put_write(8'h5A, 1'b0, 1'b0);
        put_write(8'h33, 1'b1, 1'b1);
        put_write(8'hA5, 1'b1, 1'b0);
        repeat (5) put_drain();

        run_random(60, 50);
        rx_hold_req = 1'b1;
        run_random(30, 50);
        wait_results_drained();
        run_random(80, 15);
        run_random(60, 80);
        run_overlong_packet();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        run_random(40, 50);

        wait_results_drained();
        repeat (20) @(posedge i_clk);

        $display("run: %0d transfers in, %0d out, %0d slots released (%0d zero-length)",
                 sb.n_items, sb.n_results, sb.n_released, sb.n_empty_loads);
        $display("     %0d bytes emitted, %0d packets dropped, %0d bytes truncated, %0d mismatches",
                 sb.n_emitted, sb.n_dropped, sb.n_truncated, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_results.size() == 0) begin
            $display("PASS packet_fifo_byte_drain_top");
        end else begin
            $display("FAIL packet_fifo_byte_drain_top");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/pfbd_pkg.sv
rtl/core/pfbd_front.sv
rtl/core/pfbd_back.sv
rtl/core/packet_fifo_byte_drain_top.sv
tb/packet_fifo_byte_drain_top_tb.sv
